/* rtl/rvsc_pkg.sv */
// Package for the release version string checker.
// Holds the character codes, limits, parse phase type and parse state struct.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rvsc_pkg;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 9;
    localparam int PART_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_V    = 8'h76;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    localparam logic [LEN_W-1:0]  LEN_SAT   = 9'd256;
    localparam logic [LEN_W-1:0]  MIN_LEN   = 9'd6;
    localparam logic [PART_W-1:0] PART_LAST = 2'd2;

    localparam logic [CHAR_W-1:0] MAX_LEN_RESET = 8'd32;

    typedef enum logic [2:0] {
        PH_WANT_V     = 3'd0,
        PH_PART_START = 3'd1,
        PH_ZERO       = 3'd2,
        PH_DIGITS     = 3'd3,
        PH_REJECT     = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [PART_W-1:0]   part_count;
        logic [LEN_W-1:0]    length_count;
    } parse_state_t;

endpackage

/* rtl/rvsc_step.sv */
// Combinational parse step: one byte against the current parse state.
// Gives the next state and the verdict for a final byte.
// Depends on rvsc_pkg.
`timescale 1ns / 1ps

module rvsc_step import rvsc_pkg::*; (
    input  parse_state_t       cur_state,
    input  logic [CHAR_W-1:0]  char_in,
    input  logic               last,
    input  logic [CHAR_W-1:0]  maximum_length,
    output parse_state_t       next_state,
    output logic               ok
);

    phase_t            ph;
    logic [PART_W-1:0] part;
    logic [LEN_W-1:0]  len;
    logic              is_digit;
    phase_t            dot_phase;
    logic [PART_W-1:0] dot_part;

    always_comb begin
        is_digit = char_in inside {[CHAR_ZERO:CHAR_NINE]};
        len      = (cur_state.length_count == LEN_SAT) ? LEN_SAT
                                                       : cur_state.length_count + 9'd1;
        if (cur_state.part_count < PART_LAST) begin
            dot_phase = PH_PART_START;
            dot_part  = cur_state.part_count + 2'd1;
        end else begin
            dot_phase = PH_REJECT;
            dot_part  = cur_state.part_count;
        end

        part = cur_state.part_count;
        case (cur_state.phase)
            PH_WANT_V: begin
                ph = (char_in == CHAR_V) ? PH_PART_START : PH_REJECT;
            end
            PH_PART_START: begin
                if (char_in == CHAR_ZERO) begin
                    ph = PH_ZERO;
                end else if (is_digit) begin
                    ph = PH_DIGITS;
                end else begin
                    ph = PH_REJECT;
                end
            end
            PH_ZERO: begin
                if (char_in == CHAR_DOT) begin
                    ph   = dot_phase;
                    part = dot_part;
                end else begin
                    ph = PH_REJECT;
                end
            end
            PH_DIGITS: begin
                if (char_in == CHAR_DOT) begin
                    ph   = dot_phase;
                    part = dot_part;
                end else if (is_digit) begin
                    ph = PH_DIGITS;
                end else begin
                    ph = PH_REJECT;
                end
            end
            default: begin
                ph = PH_REJECT;
            end
        endcase

        ok = (ph == PH_ZERO || ph == PH_DIGITS) && (part == PART_LAST) &&
             (len >= MIN_LEN) && (len <= {1'b0, maximum_length});

        if (last) begin
            next_state.phase        = PH_WANT_V;
            next_state.part_count   = '0;
            next_state.length_count = '0;
        end else begin
            next_state.phase        = ph;
            next_state.part_count   = part;
            next_state.length_count = len;
        end
    end

endmodule

/* rtl/rvsc_result_reg.sv */
// Result register of the checker: holds one verdict until the sink takes it.
// Reports whether a new verdict may be loaded in this cycle.
// Depends on rvsc_pkg.
`timescale 1ns / 1ps

module rvsc_result_reg import rvsc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic load,
    input  logic ok,
    output logic free,
    output logic m_valid,
    output logic m_valid_res,
    input  logic m_ready
);

    logic valid_reg;
    logic valid_next;
    logic res_reg;

    assign free        = !valid_reg || m_ready;
    assign m_valid     = valid_reg;
    assign m_valid_res = res_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= ok;
        end
    end

endmodule

/* rtl/release_version_string_checker_core.sv */
// Top level of the release version string checker.
// Instantiates rvsc_step and rvsc_result_reg; depends on rvsc_pkg.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   s_char_in[7:0], s_last
//   m_        out        m_valid / m_ready   m_valid_res
//   cfg_      in         cfg_wr_en           cfg_wr_data[7:0] (maximum length)
//
// One byte is taken per cycle while no final byte waits for the result slot. A byte
// passes an input register, then the parse step, and the verdict for a final byte is
// loaded into the result register when that register is free. A stalled sink holds the
// verdict while further bytes of the next string are still parsed; only a second final
// byte waits for the slot. Reset is synchronous and sets the maximum length to 32.
`timescale 1ns / 1ps

module release_version_string_checker_core import rvsc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CHAR_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_char_in,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_valid_res
);

    logic [CHAR_W-1:0] max_len_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic              step_ok;
    logic              res_free;
    logic              advance;
    logic              s_take;

    assign advance = in_valid_reg && (!in_last_reg || res_free);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    rvsc_step u_step (
        .cur_state      (state_reg),
        .char_in        (in_char_reg),
        .last           (in_last_reg),
        .maximum_length (max_len_reg),
        .next_state     (state_next),
        .ok             (step_ok)
    );

    rvsc_result_reg u_result (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance && in_last_reg),
        .ok          (step_ok),
        .free        (res_free),
        .m_valid     (m_valid),
        .m_valid_res (m_valid_res),
        .m_ready     (m_ready)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg            <= MAX_LEN_RESET;
            in_valid_reg           <= 1'b0;
            state_reg.phase        <= PH_WANT_V;
            state_reg.part_count   <= '0;
            state_reg.length_count <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_char_reg <= s_char_in;
            in_last_reg <= s_last;
        end
    end

    a_final_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> m_valid)
        else $error("Final byte did not produce a result item.");

    a_final_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> state_reg.phase == PH_WANT_V &&
            state_reg.part_count == '0 && state_reg.length_count == '0)
        else $error("Parse state not cleared after final byte.");

    a_part_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.part_count <= PART_LAST)
        else $error("Part count beyond third part.");

    a_len_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.length_count <= LEN_SAT)
        else $error("Length counter passed its saturation value.");

    a_stall_holds_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_char_reg))
        else $error("Held byte lost while waiting for the result slot.");

endmodule

/* bench/release_version_string_checker_core_tb.sv */
// Testbench for the release version string checker core.
// Streams version strings through the block against an internal parse predictor.
// Depends on rvsc_pkg and release_version_string_checker_core.
`timescale 1ns / 1ps

module release_version_string_checker_core_tb;
    import rvsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int ROUND_BYTES    = 110;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CHAR_W-1:0] cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic [CHAR_W-1:0] s_char_in;
    logic              s_last;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_valid_res;

    phase_t            parse_phase;
    logic [PART_W-1:0] part_idx;
    logic [LEN_W-1:0]  byte_count;
    logic [CHAR_W-1:0] max_length;

    logic verdict_q[$];
    int   err_count     = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    bit   src_idle_en   = 1'b1;
    bit   sink_idle_en  = 1'b1;

    release_version_string_checker_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_in   (s_char_in),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // Advances the parse state by one byte; returns 1 when the byte closes a string.
    function automatic bit parse_byte(input logic [CHAR_W-1:0] c, input logic fin,
                                      output logic verdict);
        logic is_dig;
        is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        if (byte_count < LEN_SAT) byte_count = byte_count + 1'b1;
        case (parse_phase)
            PH_WANT_V: begin
                parse_phase = (c == CHAR_V) ? PH_PART_START : PH_REJECT;
            end
            PH_PART_START: begin
                if (c == CHAR_ZERO) parse_phase = PH_ZERO;
                else if (is_dig) parse_phase = PH_DIGITS;
                else parse_phase = PH_REJECT;
            end
            PH_ZERO, PH_DIGITS: begin
                if (c == CHAR_DOT) begin
                    if (part_idx < PART_LAST) begin
                        part_idx    = part_idx + 1'b1;
                        parse_phase = PH_PART_START;
                    end else begin
                        parse_phase = PH_REJECT;
                    end
                end else if (!is_dig || parse_phase == PH_ZERO) begin
                    parse_phase = PH_REJECT;
                end
            end
            default: begin
                parse_phase = PH_REJECT;
            end
        endcase
        verdict = (parse_phase == PH_ZERO || parse_phase == PH_DIGITS) &&
                  part_idx == PART_LAST && byte_count >= MIN_LEN &&
                  byte_count <= {1'b0, max_length};
        if (fin) begin
            parse_phase = PH_WANT_V;
            part_idx    = '0;
            byte_count  = '0;
        end
        return fin;
    endfunction

    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic fin);
        logic verdict;
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        s_last    <= fin;
        do @(posedge aclk); while (!s_ready);
        if (parse_byte(c, fin, verdict)) verdict_q.push_back(verdict);
    endtask

    task automatic send_text(input string text, input logic fin);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i], fin && (i == text.len() - 1));
        end
    endtask

    task automatic send_long_version(input int total);
        send_text("v1.2.", 1'b0);
        for (int i = 0; i < total - 5; i++) begin
            send_byte((i == 0) ? CHAR_ZERO + 8'd7 : CHAR_ZERO, i == total - 6);
        end
    endtask

    task automatic wait_for_results;
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_max_length(input logic [CHAR_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        max_length = value;
    endtask

    function automatic void make_version(ref logic [CHAR_W-1:0] text[$]);
        int parts;
        int digits;
        int pos;
        text.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) text.push_back(8'($urandom));
            return;
        end
        text.push_back(CHAR_V);
        parts = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 3;
        for (int p = 0; p < parts; p++) begin
            if (p > 0) text.push_back(CHAR_DOT);
            digits = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 24)
                                                   : $urandom_range(1, 3);
            for (int d = 0; d < digits; d++) begin
                if (d == 0 && $urandom_range(0, 3) == 0) text.push_back(CHAR_ZERO);
                else text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 2))
                0: text[pos] = 8'($urandom);
                1: text.insert(pos, 8'($urandom));
                default: if (text.size() > 1) text.delete(pos);
            endcase
        end
    endfunction

    task automatic test_default_limit;
        send_text("v1.2.3", 1'b1);
        send_text("v0.0.0", 1'b1);
        send_text("v10.20.30", 1'b1);
        send_text("v01.2.3", 1'b1);
        send_text("v1.2", 1'b1);
        send_text("v1.2.3.4", 1'b1);
        send_text("v1.2.3x", 1'b1);
        send_text("V1.2.3", 1'b1);
        send_text("v.1.2", 1'b1);
        send_text("v", 1'b1);
        send_text("v1.", 1'b0);
        send_byte(8'h00, 1'b0);
        send_text(".3", 1'b1);
        send_text("v9.9.", 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_length_limits;
        set_max_length(8'd6);
        send_text("v1.2.3", 1'b1);
        send_text("v1.2.34", 1'b1);
        set_max_length(8'd5);
        send_text("v1.2.3", 1'b1);
        set_max_length(8'd0);
        send_text("v1.2.3", 1'b1);
        set_max_length(8'd255);
        send_long_version(255);
        send_long_version(257);
        set_max_length(MAX_LEN_RESET);
    endtask

    task automatic test_backpressure;
        src_idle_en = 1'b0;
        hold_requests <= hold_requests + 1;
        repeat (30) begin
            if ($urandom_range(0, 1) == 0) begin
                send_text("v1.2.3", 1'b1);
            end else begin
                send_text("v12.0.7x", 1'b1);
            end
        end
        wait_for_results();
        src_idle_en = 1'b1;
    endtask

    task automatic test_random_strings;
        logic [CHAR_W-1:0] text[$];
        logic [CHAR_W-1:0] limits[8];
        int sent;
        limits = '{MAX_LEN_RESET, 8'd6, 8'd255, 8'($urandom_range(6, 40)), 8'd5,
                   8'($urandom), 8'd12, 8'($urandom_range(10, 24))};
        for (int round = 0; round < 8; round++) begin
            src_idle_en  = (round != 2) && (round != 7);
            sink_idle_en = (round != 3) && (round != 7);
            set_max_length(limits[round]);
            sent = 0;
            while (sent < ROUND_BYTES) begin
                make_version(text);
                for (int i = 0; i < text.size(); i++) begin
                    send_byte(text[i], i == text.size() - 1);
                end
                sent += text.size();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report_error("result item arrived with none expected");
            end else if (m_valid_res !== verdict_q[0]) begin
                report_error($sformatf("valid_res %b, expected %b", m_valid_res,
                                       verdict_q[0]));
                void'(verdict_q.pop_front());
            end else begin
                void'(verdict_q.pop_front());
            end
        end
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(0, 16);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_char_in   = '0;
        s_last      = 1'b0;
        parse_phase = PH_WANT_V;
        part_idx    = '0;
        byte_count  = '0;
        max_length  = MAX_LEN_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_limit();
        test_length_limits();
        test_backpressure();
        test_random_strings();
        wait_for_results();
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
